[hw/rtl/stfq_pkg.sv]
// ----------------------------------------------------------------------------
// stfq_pkg: shared types and constants for the start-time fair queue pacer
// Tag, time and queue slot formats, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package stfq_pkg;

  localparam int TagW        = 48;
  localparam int TimeW       = 32;
  localparam int FlowW       = 6;
  localparam int LenW        = 16;
  localparam int WeightW     = 16;
  localparam int RateW       = 30;
  localparam int WeightFracW = 8;
  localparam int MsPerS      = 1000;

  localparam int DefNumFlows   = 64;
  localparam int DefQueueDepth = 16;
  localparam int DefTagFrac    = 16;

  localparam logic [RateW-1:0] RateReset = RateW'(1000000);

  localparam logic STATUS_GRANT = 1'b0;
  localparam logic STATUS_DROP  = 1'b1;
  localparam logic KIND_SEND    = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef struct packed {
    logic [TagW-1:0]  start;
    logic [TagW-1:0]  finish;
    logic [FlowW-1:0] flow;
    logic [LenW-1:0]  length;
    logic [TimeW-1:0] age;
  } slot_t;

endpackage

`default_nettype wire

[hw/rtl/stfq_div.sv]
// ----------------------------------------------------------------------------
// stfq_div: shared restoring divider
// One quotient bit per cycle; result held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module stfq_div #(
  parameter int DividendW = 40,
  parameter int DivisorW  = 30
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DividendW-1:0]      quotient_o
);
  localparam int CntW = $clog2(DividendW + 1);

  logic [CntW-1:0]      cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [DivisorW:0]    rem_q;
  logic [DivisorW-1:0]  dvs_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW:0]    trial;
  logic                 fits;

  assign trial = {rem_q[DivisorW-1:0], quo_q[DividendW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DividendW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
      quo_q <= {quo_q[DividendW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[hw/rtl/start_time_fair_queue_pacer.sv]
// ----------------------------------------------------------------------------
// start_time_fair_queue_pacer: start-time fair queuing with rate pacing
// Tags requests, queues them and grants the smallest start tag when the
// pacing deadline has passed.
// ----------------------------------------------------------------------------
//  channel   signals                                      transfer
//  request   start, busy, kind_i, flow_id_i, weight_i,    start && !busy
//            length_i
//  result    done_o, status_o, grant_flow_o,              done_o (one cycle)
//            grant_length_o, start_tag_o, finish_tag_o
//  config    psel, penable, pwrite, paddr, pwdata,        psel&penable&pwrite
//            prdata, pready
//
//  A send request reads the flow's finish tag; then the shared divider runs
//  once for the tag increment and once for the pacing gap, one quotient bit
//  per cycle, and the grant scan reads one queue slot per cycle. A drop ends
//  after the tag division, a send before the deadline after the deadline
//  check. A tick runs the deadline check, then the scan and, when a grant
//  is made, the gap division; it ends after a scan that finds nothing and
//  after the check before the deadline. busy is high for the whole item.
//  Reset clears all control state, flow finish valid bits and slot valids at
//  once; no clearing pass. The result receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module start_time_fair_queue_pacer #(
  parameter int NUM_FLOWS     = stfq_pkg::DefNumFlows,
  parameter int QUEUE_DEPTH   = stfq_pkg::DefQueueDepth,
  parameter int TAG_FRAC_BITS = stfq_pkg::DefTagFrac
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind_i,
  input  wire logic [stfq_pkg::FlowW-1:0]    flow_id_i,
  input  wire logic [stfq_pkg::WeightW-1:0]  weight_i,
  input  wire logic [stfq_pkg::LenW-1:0]     length_i,
  output logic                               done_o,
  output logic                               status_o,
  output logic [stfq_pkg::FlowW-1:0]         grant_flow_o,
  output logic [stfq_pkg::LenW-1:0]          grant_length_o,
  output logic [stfq_pkg::TagW-1:0]          start_tag_o,
  output logic [stfq_pkg::TagW-1:0]          finish_tag_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import stfq_pkg::*;

  localparam int IW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int FW     = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int SHIFT  = WeightFracW + TAG_FRAC_BITS;
  localparam int DIV_W  = (LenW + SHIFT > 26) ? (LenW + SHIFT) : 26;
  localparam logic [2:0] ADDR_MAX_RATE = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_TAGDIV, ST_CHECK, ST_SCAN, ST_GAPDIV
  } state_e;

  // flow index wraps at NUM_FLOWS: FlowW compare/subtract steps
  function automatic logic [FW-1:0] flow_idx(input logic [FlowW-1:0] f);
    logic [FlowW:0] r;
    r = {1'b0, f};
    for (int k = FlowW - 1; k >= 0; k--) begin
      if (32'(r) >= (NUM_FLOWS << k)) r = r - (FlowW+1)'(NUM_FLOWS << k);
    end
    return FW'(r);
  endfunction

  state_e             state_q;
  logic [RateW-1:0]   rate_q;
  logic [TagW-1:0]    vt_q, largest_q;
  logic [TimeW-1:0]   now_q, deadline_q, arrival_q;
  logic [QUEUE_DEPTH-1:0] slot_valid_q;
  logic [NUM_FLOWS-1:0]   flow_vld_q;

  // request latch
  logic [FlowW-1:0]   req_flow_q;
  logic [LenW-1:0]    req_len_q;
  logic [WeightW-1:0] req_weight_q;
  logic [TagW-1:0]    req_start_q;
  logic               flow_rdv_q;

  // memories
  logic [TagW-1:0] flow_mem [NUM_FLOWS];
  logic [TagW-1:0] flow_rd_q;
  slot_t           slot_mem [QUEUE_DEPTH];
  slot_t           slot_rd_q;

  // scan
  logic [CW-1:0]    cnt_q;
  logic             pend_q, rdv_q, found_q;
  logic [IW-1:0]    rd_idx_q, best_idx_q;
  slot_t            best_q;
  logic [TimeW-1:0] best_dist_q;

  // divider
  logic             div_start_q;
  logic [DIV_W-1:0] div_dividend_q;
  logic [RateW-1:0] div_divisor_q;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  // result
  logic             done_q, status_q;
  logic [FlowW-1:0] out_flow_q;
  logic [LenW-1:0]  out_len_q;
  logic [TagW-1:0]  out_start_q, out_finish_q;

  logic [TagW-1:0]  fl_eff, start_calc, finish_calc;
  logic [TagW:0]    finish_sum;
  logic [TimeW:0]   dl_sum;
  logic [TimeW-1:0] dl_sat, age_dist;
  logic [IW-1:0]    free_idx;
  logic             any_free, better;
  logic             slot_we, flow_we;
  slot_t            slot_wdata;
  logic [FW-1:0]    wr_flow_idx;
  logic [IW-1:0]    rd_addr;

  stfq_div #(.DividendW(DIV_W), .DivisorW(RateW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend_q),
    .divisor_i  (div_divisor_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign fl_eff      = flow_rdv_q ? flow_rd_q : '0;
  assign start_calc  = (vt_q > fl_eff) ? vt_q : fl_eff;
  assign finish_sum  = {1'b0, req_start_q} + (TagW+1)'(div_quo);
  assign finish_calc = finish_sum[TagW] ? '1 : finish_sum[TagW-1:0];
  assign dl_sum      = {1'b0, now_q} + (TimeW+1)'(div_quo);
  assign dl_sat      = dl_sum[TimeW] ? '1 : dl_sum[TimeW-1:0];
  assign age_dist    = arrival_q - slot_rd_q.age;
  assign any_free    = ~&slot_valid_q;
  assign better      = !found_q || (slot_rd_q.start < best_q.start) ||
                       ((slot_rd_q.start == best_q.start) && (age_dist > best_dist_q));
  assign rd_addr     = cnt_q[IW-1:0];

  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) free_idx = IW'(i);
    end
  end

  assign slot_we     = (state_q == ST_TAGDIV) && div_done && any_free;
  assign slot_wdata  = '{start: req_start_q, finish: finish_calc, flow: req_flow_q,
                         length: req_len_q, age: arrival_q};
  assign flow_we     = (state_q == ST_GAPDIV) && div_done;
  assign wr_flow_idx = flow_idx(best_q.flow);

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[free_idx] <= slot_wdata;
    slot_rd_q <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (flow_we) flow_mem[wr_flow_idx] <= best_q.finish;
    flow_rd_q <= flow_mem[flow_idx(flow_id_i)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rate_q       <= RateReset;
      vt_q         <= '0;
      largest_q    <= '0;
      now_q        <= '0;
      deadline_q   <= '0;
      arrival_q    <= '0;
      slot_valid_q <= '0;
      flow_vld_q   <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      rdv_q        <= 1'b0;
      found_q      <= 1'b0;
      div_start_q  <= 1'b0;
      done_q       <= 1'b0;
      status_q     <= STATUS_GRANT;
    end else begin
      done_q      <= 1'b0;
      div_start_q <= 1'b0;
      if (psel && penable && pwrite && (paddr == ADDR_MAX_RATE)) begin
        rate_q <= pwdata[RateW-1:0];
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            req_flow_q   <= flow_id_i;
            req_len_q    <= length_i;
            req_weight_q <= weight_i;
            flow_rdv_q   <= flow_vld_q[flow_idx(flow_id_i)];
            if (kind_i == KIND_TICK) begin
              if (now_q != '1) now_q <= now_q + 1'b1;
              state_q <= ST_CHECK;
            end else begin
              if (~|slot_valid_q) vt_q <= largest_q;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          req_start_q    <= start_calc;
          div_dividend_q <= DIV_W'(req_len_q) << SHIFT;
          div_divisor_q  <= (req_weight_q == '0) ? RateW'(1) : RateW'(req_weight_q);
          div_start_q    <= 1'b1;
          state_q        <= ST_TAGDIV;
        end
        ST_TAGDIV: begin
          if (div_done) begin
            if (!any_free) begin
              done_q       <= 1'b1;
              status_q     <= STATUS_DROP;
              out_flow_q   <= req_flow_q;
              out_len_q    <= req_len_q;
              out_start_q  <= req_start_q;
              out_finish_q <= finish_calc;
              state_q      <= ST_IDLE;
            end else begin
              if (finish_calc > largest_q) largest_q <= finish_calc;
              slot_valid_q[free_idx] <= 1'b1;
              arrival_q <= arrival_q + 1'b1;
              state_q   <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          cnt_q   <= '0;
          pend_q  <= 1'b0;
          found_q <= 1'b0;
          state_q <= (now_q < deadline_q) ? ST_IDLE : ST_SCAN;
        end
        ST_SCAN: begin
          // read slot cnt, compare the one read last cycle
          if (cnt_q != CW'(QUEUE_DEPTH)) begin
            pend_q   <= 1'b1;
            rdv_q    <= slot_valid_q[rd_addr];
            rd_idx_q <= rd_addr;
            cnt_q    <= cnt_q + 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q && rdv_q && better) begin
            found_q     <= 1'b1;
            best_q      <= slot_rd_q;
            best_idx_q  <= rd_idx_q;
            best_dist_q <= age_dist;
          end
          if ((cnt_q == CW'(QUEUE_DEPTH)) && !pend_q) begin
            if (found_q) begin
              div_dividend_q <= DIV_W'(best_q.length * 26'(MsPerS));
              div_divisor_q  <= (rate_q == '0) ? RateW'(1) : rate_q;
              div_start_q    <= 1'b1;
              state_q        <= ST_GAPDIV;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_GAPDIV: begin
          if (div_done) begin
            vt_q                     <= best_q.start;
            flow_vld_q[wr_flow_idx]  <= 1'b1;
            deadline_q               <= dl_sat;
            slot_valid_q[best_idx_q] <= 1'b0;
            done_q       <= 1'b1;
            status_q     <= STATUS_GRANT;
            out_flow_q   <= best_q.flow;
            out_len_q    <= best_q.length;
            out_start_q  <= best_q.start;
            out_finish_q <= best_q.finish;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign grant_flow_o   = out_flow_q;
  assign grant_length_o = out_len_q;
  assign start_tag_o    = out_start_q;
  assign finish_tag_o   = out_finish_q;
  assign prdata         = (paddr == ADDR_MAX_RATE) ? 32'(rate_q) : '0;
  assign pready         = 1'b1;

`ifndef SYNTHESIS
  // a result only ever closes an item in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without item in flight");
  // drops only happen with a full queue
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_DROP) |-> (&slot_valid_q))
    else $error("drop while queue has room");
  // a grant frees its slot
  a_grant_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_GRANT) |-> !(&slot_valid_q))
    else $error("grant left queue full");
  // divider never restarted while a result goes out
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !div_start_q) else $error("divider started on result");
`endif

endmodule

`default_nettype wire
